// ===== rtl/core/tridiagonal_thomas_solver_assert.svh =====
// ============================================================================
// Assertion macros for the tridiagonal solver
// Shorthands for clocked implications on i_clk, disabled while i_rst_n is low.
// ============================================================================
`ifndef TRIDIAGONAL_THOMAS_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_ASSERT_SVH

// Same-cycle implication.
`define TTS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tts_pkg.sv =====
// ============================================================================
// tts_pkg
// Number format, complex and row types, and saturation shared by the solver.
// ============================================================================
`default_nettype none

package tts_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ROW_IDX_W = 6;
    localparam int ACC_W     = 66;
    localparam int MAG_W     = 64;
    localparam int SAT_W     = 48;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word re;
        t_word im;
    } t_cpx;

    typedef struct packed {
        t_cpx diag;
        t_cpx rhs;
        t_cpx upper;
    } t_row;

    typedef logic t_op;
    localparam t_op OP_MULSUB = 1'b0;
    localparam t_op OP_DIV    = 1'b1;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_calc_cmd;

    typedef struct packed {
        logic done;
        logic zero;
    } t_calc_rsp;

    // Signed word from a sign and a magnitude, clamped to the word range.
    function automatic t_word sat_word(input logic neg, input logic [SAT_W-1:0] mag);
        logic [SAT_W-1:0] lim;
        logic [SAT_W-1:0] v;
        lim = neg ? (SAT_W'(1) << (WORD_W - 1)) : ((SAT_W'(1) << (WORD_W - 1)) - SAT_W'(1));
        v   = (mag > lim) ? lim : mag;
        return neg ? t_word'(~v[WORD_W-1:0] + WORD_W'(1)) : t_word'(v[WORD_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tts_ram.sv =====
// ============================================================================
// tts_ram
// Simple dual-port RAM with one write port and a registered read port.
// ============================================================================
`default_nettype none

module tts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/tts_div.sv =====
// ============================================================================
// tts_div
// Bit-serial fixed-point divider: |num| * 2^FRAC / den, truncated, saturated.
// ============================================================================
`default_nettype none

module tts_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic signed [tts_pkg::ACC_W-1:0] i_num,
    input  wire logic        [tts_pkg::MAG_W-1:0] i_den,
    output logic                               o_done,
    output tts_pkg::t_word                     o_q
);
    import tts_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic               r_prep;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [MAG_W-1:0]   r_mag;
    logic               r_neg;
    logic [MAG_W-1:0]   r_den;
    logic               r_ovf;
    logic [MAG_W:0]     r_rem;
    logic [WORD_W-1:0]  r_low;
    logic [WORD_W-1:0]  r_q;

    logic signed [ACC_W-1:0] w_abs;
    logic [MAG_W:0]          w_rem_sh;
    logic                    w_ge;
    logic [MAG_W:0]          w_rem_nx;

    assign w_abs    = i_num[ACC_W-1] ? -i_num : i_num;
    assign w_rem_sh = {r_rem[MAG_W-1:0], r_low[WORD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mag  <= w_abs[MAG_W-1:0];
                r_neg  <= i_num[ACC_W-1];
                r_den  <= i_den;
                r_prep <= 1'b1;
            end else if (r_prep) begin
                // Quotient needs more than a word exactly when |num| >= den * 2^FRAC.
                r_ovf  <= ({{FRAC_W{1'b0}}, r_mag} >= {r_den, {FRAC_W{1'b0}}});
                r_rem  <= {{(FRAC_W + 1){1'b0}}, r_mag[MAG_W-1:FRAC_W]};
                r_low  <= {r_mag[FRAC_W-1:0], {(WORD_W - FRAC_W){1'b0}}};
                r_prep <= 1'b0;
                r_cnt  <= CNT_W'(WORD_W);
            end else if (r_cnt != '0) begin
                r_rem <= w_rem_nx;
                r_low <= {r_low[WORD_W-2:0], 1'b0};
                r_q   <= {r_q[WORD_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = sat_word(r_neg, r_ovf ? {SAT_W{1'b1}} : {{(SAT_W - WORD_W){1'b0}}, r_q});

endmodule

`default_nettype wire

// ===== rtl/core/tts_calc.sv =====
// ============================================================================
// tts_calc
// Complex arithmetic unit: c - x*y or x / y over one shared 32x32 multiplier.
// ============================================================================
`default_nettype none

module tts_calc (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tts_pkg::t_calc_cmd i_cmd,
    input  wire tts_pkg::t_cpx      i_x,
    input  wire tts_pkg::t_cpx      i_y,
    input  wire tts_pkg::t_cpx      i_c,
    output tts_pkg::t_calc_rsp      o_rsp,
    output tts_pkg::t_cpx           o_res
);
    import tts_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_ABS  = 3'd2;
    localparam logic [2:0] PH_SAT  = 3'd3;
    localparam logic [2:0] PH_CHK  = 3'd4;
    localparam logic [2:0] PH_DIV  = 3'd5;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_RE   = 2'd1;
    localparam logic [1:0] ACC_IM   = 2'd2;
    localparam logic [1:0] ACC_DEN  = 2'd3;

    logic [2:0]              r_phase;
    t_op                     r_op;
    t_cpx                    r_x;
    t_cpx                    r_y;
    logic [2:0]              r_step;
    logic signed [63:0]      r_prod;
    logic                    r_pvalid;
    logic [2:0]              r_pk;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic [MAG_W-1:0]        r_den;
    logic                    r_neg_re;
    logic                    r_neg_im;
    logic [MAG_W-1:0]        r_mag_re;
    logic [MAG_W-1:0]        r_mag_im;
    logic                    r_done;
    logic                    r_zero;
    logic                    r_dstart;
    t_cpx                    r_res;

    t_word                   w_ma;
    t_word                   w_mb;
    logic signed [63:0]      w_prod;
    logic [1:0]              w_tgt;
    logic                    w_sub;
    logic [2:0]              w_nprod;
    logic signed [ACC_W-1:0] w_prod_ext;
    logic signed [ACC_W-1:0] w_addend;
    logic signed [ACC_W-1:0] w_abs_re;
    logic signed [ACC_W-1:0] w_abs_im;
    logic                    w_done_re;
    logic                    w_done_im;
    t_word                   w_q_re;
    t_word                   w_q_im;

    // Operand order of the products; the division also forms |y|^2.
    always_comb begin
        w_ma = r_x.re;
        w_mb = r_y.re;
        unique case ({r_op, r_step})
            {OP_MULSUB, 3'd0}: begin w_ma = r_x.re; w_mb = r_y.re; end
            {OP_MULSUB, 3'd1}: begin w_ma = r_x.im; w_mb = r_y.im; end
            {OP_MULSUB, 3'd2}: begin w_ma = r_x.re; w_mb = r_y.im; end
            {OP_MULSUB, 3'd3}: begin w_ma = r_x.im; w_mb = r_y.re; end
            {OP_DIV,    3'd0}: begin w_ma = r_y.re; w_mb = r_y.re; end
            {OP_DIV,    3'd1}: begin w_ma = r_y.im; w_mb = r_y.im; end
            {OP_DIV,    3'd2}: begin w_ma = r_x.re; w_mb = r_y.re; end
            {OP_DIV,    3'd3}: begin w_ma = r_x.im; w_mb = r_y.im; end
            {OP_DIV,    3'd4}: begin w_ma = r_x.im; w_mb = r_y.re; end
            {OP_DIV,    3'd5}: begin w_ma = r_x.re; w_mb = r_y.im; end
            default: begin w_ma = r_x.re; w_mb = r_y.re; end
        endcase
    end

    always_comb begin
        w_tgt = ACC_NONE;
        w_sub = 1'b0;
        unique case ({r_op, r_pk})
            {OP_MULSUB, 3'd0}: begin w_tgt = ACC_RE;  w_sub = 1'b1; end
            {OP_MULSUB, 3'd1}: begin w_tgt = ACC_RE;  w_sub = 1'b0; end
            {OP_MULSUB, 3'd2}: begin w_tgt = ACC_IM;  w_sub = 1'b1; end
            {OP_MULSUB, 3'd3}: begin w_tgt = ACC_IM;  w_sub = 1'b1; end
            {OP_DIV,    3'd0}: begin w_tgt = ACC_DEN; w_sub = 1'b0; end
            {OP_DIV,    3'd1}: begin w_tgt = ACC_DEN; w_sub = 1'b0; end
            {OP_DIV,    3'd2}: begin w_tgt = ACC_RE;  w_sub = 1'b0; end
            {OP_DIV,    3'd3}: begin w_tgt = ACC_RE;  w_sub = 1'b0; end
            {OP_DIV,    3'd4}: begin w_tgt = ACC_IM;  w_sub = 1'b0; end
            {OP_DIV,    3'd5}: begin w_tgt = ACC_IM;  w_sub = 1'b1; end
            default: begin w_tgt = ACC_NONE; w_sub = 1'b0; end
        endcase
    end

    assign w_prod     = w_ma * w_mb;
    assign w_nprod    = (r_op == OP_DIV) ? 3'd6 : 3'd4;
    assign w_prod_ext = {{(ACC_W - 64){r_prod[63]}}, r_prod};
    assign w_addend   = w_sub ? -w_prod_ext : w_prod_ext;
    assign w_abs_re   = r_acc_re[ACC_W-1] ? -r_acc_re : r_acc_re;
    assign w_abs_im   = r_acc_im[ACC_W-1] ? -r_acc_im : r_acc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
            r_zero   <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_dstart <= 1'b0;
            if (r_pvalid) begin
                unique case (w_tgt)
                    ACC_RE:  r_acc_re <= r_acc_re + w_addend;
                    ACC_IM:  r_acc_im <= r_acc_im + w_addend;
                    ACC_DEN: r_den    <= r_den + MAG_W'(r_prod);
                    default: ;
                endcase
            end
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_cmd.start) begin
                        r_op   <= i_cmd.op;
                        r_x    <= i_x;
                        r_y    <= i_y;
                        r_step <= 3'd0;
                        r_den  <= '0;
                        r_zero <= 1'b0;
                        if (i_cmd.op == OP_DIV) begin
                            r_acc_re <= '0;
                            r_acc_im <= '0;
                        end else begin
                            // c carries FRAC fraction bits; products carry twice that.
                            r_acc_re <= {{(ACC_W - WORD_W - FRAC_W){i_c.re[WORD_W-1]}},
                                         i_c.re, {FRAC_W{1'b0}}};
                            r_acc_im <= {{(ACC_W - WORD_W - FRAC_W){i_c.im[WORD_W-1]}},
                                         i_c.im, {FRAC_W{1'b0}}};
                        end
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    if (r_step != w_nprod) begin
                        r_prod   <= w_prod;
                        r_pvalid <= 1'b1;
                        r_pk     <= r_step;
                        r_step   <= r_step + 3'd1;
                    end else begin
                        r_pvalid <= 1'b0;
                        r_phase  <= (r_op == OP_DIV) ? PH_CHK : PH_ABS;
                    end
                end
                PH_ABS: begin
                    r_neg_re <= r_acc_re[ACC_W-1];
                    r_neg_im <= r_acc_im[ACC_W-1];
                    r_mag_re <= w_abs_re[MAG_W-1:0];
                    r_mag_im <= w_abs_im[MAG_W-1:0];
                    r_phase  <= PH_SAT;
                end
                PH_SAT: begin
                    r_res.re <= sat_word(r_neg_re, r_mag_re[MAG_W-1:FRAC_W]);
                    r_res.im <= sat_word(r_neg_im, r_mag_im[MAG_W-1:FRAC_W]);
                    r_done   <= 1'b1;
                    r_phase  <= PH_IDLE;
                end
                PH_CHK: begin
                    if (r_den == '0) begin
                        r_res   <= '0;
                        r_zero  <= 1'b1;
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end else begin
                        r_dstart <= 1'b1;
                        r_phase  <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    if (w_done_re & w_done_im) begin
                        r_res.re <= w_q_re;
                        r_res.im <= w_q_im;
                        r_done   <= 1'b1;
                        r_phase  <= PH_IDLE;
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    tts_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_acc_re),
        .i_den   (r_den),
        .o_done  (w_done_re),
        .o_q     (w_q_re)
    );

    tts_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_acc_im),
        .i_den   (r_den),
        .o_done  (w_done_im),
        .o_q     (w_q_im)
    );

    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;
    assign o_res      = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/tridiagonal_thomas_solver.sv =====
// ============================================================================
// tridiagonal_thomas_solver
// Complex tridiagonal solver (Thomas algorithm) in signed Q15.16.
// ============================================================================
// Rows of the system arrive one request at a time from row 0 upward, each
// carrying its lower, diagonal, upper and right-hand side coefficients.
// Forward elimination runs as each row arrives and the modified row is kept in
// a row memory of MAX_ROWS entries; a row that arrives after MAX_ROWS rows are
// held is not stored. The row flagged last_row starts back substitution, which
// solves every entry, keeps the solutions in a second memory, and then returns
// them as result requests from the last row down to row 0, with last_result on
// row 0 and div_fault set on every result if any division of the system had a
// zero divisor (that quotient is taken as zero). All arithmetic goes through
// one 32x32 multiplier and a pair of bit-serial dividers that deliver one
// quotient bit per cycle. Each row after row 0 takes a complex division and
// two multiply-subtracts, and is taken only once the one before is stored;
// back substitution takes a division per row and a multiply-subtract per row
// below the top. Results leave one at a time as the receiver takes them. No
// new row is accepted between a last row and the loading of its final result;
// the final result may still be waiting while the next system starts.
// ============================================================================
`default_nettype none

module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire tts_pkg::t_word       i_lower_re,
    input  wire tts_pkg::t_word       i_lower_im,
    input  wire tts_pkg::t_word       i_diag_re,
    input  wire tts_pkg::t_word       i_diag_im,
    input  wire tts_pkg::t_word       i_upper_re,
    input  wire tts_pkg::t_word       i_upper_im,
    input  wire tts_pkg::t_word       i_rhs_re,
    input  wire tts_pkg::t_word       i_rhs_im,
    input  wire logic                 i_last_row,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [tts_pkg::ROW_IDX_W-1:0] o_row_index,
    output tts_pkg::t_word            o_sol_re,
    output tts_pkg::t_word            o_sol_im,
    output logic                      o_div_fault,
    output logic                      o_last_result
);
    import tts_pkg::*;

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;   // waiting for a row
    localparam logic [3:0] S_PIV   = 4'd1;   // multiplier = lower / previous diagonal
    localparam logic [3:0] S_FD    = 4'd2;   // modified diagonal
    localparam logic [3:0] S_FR    = 4'd3;   // modified right-hand side, then store
    localparam logic [3:0] S_BINIT = 4'd4;   // set up back substitution on the top row
    localparam logic [3:0] S_BDIV  = 4'd5;   // solution entry = numerator / diagonal
    localparam logic [3:0] S_BRD   = 4'd6;   // row memory read of the row below
    localparam logic [3:0] S_BMS   = 4'd7;   // numerator = rhs - upper * solution above
    localparam logic [3:0] S_ERD   = 4'd8;   // solution memory read
    localparam logic [3:0] S_EOUT  = 4'd9;   // load the result register

    logic [3:0]    r_state;
    logic          r_go;
    logic [CW-1:0] r_count;
    logic          r_fault;
    logic          r_last;
    t_cpx          r_lower;
    t_cpx          r_diag;
    t_cpx          r_upper;
    t_cpx          r_rhs;
    t_row          r_prev;
    t_row          r_cur;
    t_cpx          r_piv;
    t_cpx          r_nd;
    t_cpx          r_tmp;
    t_cpx          r_sol;
    logic [AW-1:0] r_bi;
    logic [AW-1:0] r_ei;

    logic                 r_ov;
    logic [ROW_IDX_W-1:0] r_o_idx;
    t_cpx                 r_o_sol;
    logic                 r_o_fault;
    logic                 r_o_last;

    logic          w_take;
    logic          w_full;
    logic [CW-1:0] w_cnt_m1;
    logic          w_out_free;
    t_calc_cmd     w_cmd;
    t_calc_rsp     w_rsp;
    t_cpx          w_x;
    t_cpx          w_y;
    t_cpx          w_c;
    t_cpx          w_res;
    logic          w_mw_we;
    logic [AW-1:0] w_mw_addr;
    t_row          w_mw_data;
    logic          w_mr_re;
    logic [AW-1:0] w_mr_addr;
    t_row          w_mr_data;
    logic          w_sw_we;
    logic          w_sr_re;
    t_cpx          w_sr_data;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_take     = i_in_valid & o_in_ready;
    assign w_full     = (r_count == CW'(MAX_ROWS));
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_out_free = !r_ov || i_out_ready;

    // Operands for the arithmetic unit; it samples them only on a start.
    always_comb begin
        w_cmd.start = r_go;
        w_cmd.op    = OP_MULSUB;
        w_x         = r_piv;
        w_y         = r_prev.upper;
        w_c         = r_diag;
        unique case (r_state)
            S_PIV: begin
                w_cmd.op = OP_DIV;
                w_x      = r_lower;
                w_y      = r_prev.diag;
            end
            S_FD: begin
                w_c = r_diag;
                w_x = r_piv;
                w_y = r_prev.upper;
            end
            S_FR: begin
                w_c = r_rhs;
                w_x = r_piv;
                w_y = r_prev.rhs;
            end
            S_BDIV: begin
                w_cmd.op = OP_DIV;
                w_x      = r_tmp;
                w_y      = r_cur.diag;
            end
            S_BMS: begin
                w_c = r_cur.rhs;
                w_x = r_cur.upper;
                w_y = r_sol;
            end
            default: ;
        endcase
    end

    // Row memory write: row 0 straight from the request, later rows after
    // elimination. The same word is kept in r_prev, so the next row never
    // has to read back what was just written.
    always_comb begin
        w_mw_we   = 1'b0;
        w_mw_addr = r_count[AW-1:0];
        w_mw_data.diag  = r_nd;
        w_mw_data.rhs   = w_res;
        w_mw_data.upper = r_upper;
        if (r_state == S_IDLE && w_take && !w_full && r_count == '0) begin
            w_mw_we         = 1'b1;
            w_mw_data.diag  = '{re: i_diag_re, im: i_diag_im};
            w_mw_data.rhs   = '{re: i_rhs_re, im: i_rhs_im};
            w_mw_data.upper = '{re: i_upper_re, im: i_upper_im};
        end else if (r_state == S_FR && w_rsp.done) begin
            w_mw_we = 1'b1;
        end
    end

    assign w_mr_re   = (r_state == S_BDIV) && w_rsp.done && (r_bi != '0);
    assign w_mr_addr = r_bi - AW'(1);
    assign w_sw_we   = (r_state == S_BDIV) && w_rsp.done;
    assign w_sr_re   = (r_state == S_ERD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_count <= '0;
            r_fault <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (w_mw_we) begin
                r_prev <= w_mw_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_lower <= '{re: i_lower_re, im: i_lower_im};
                        r_diag  <= '{re: i_diag_re, im: i_diag_im};
                        r_upper <= '{re: i_upper_re, im: i_upper_im};
                        r_rhs   <= '{re: i_rhs_re, im: i_rhs_im};
                        r_last  <= i_last_row;
                        if (w_full) begin
                            // Extra rows are dropped, but a last flag still ends the system.
                            if (i_last_row) begin
                                r_state <= S_BINIT;
                            end
                        end else if (r_count == '0) begin
                            r_count <= CW'(1);
                            if (i_last_row) begin
                                r_state <= S_BINIT;
                            end
                        end else begin
                            r_go    <= 1'b1;
                            r_state <= S_PIV;
                        end
                    end
                end
                S_PIV: begin
                    if (w_rsp.done) begin
                        r_piv   <= w_res;
                        r_fault <= r_fault | w_rsp.zero;
                        r_go    <= 1'b1;
                        r_state <= S_FD;
                    end
                end
                S_FD: begin
                    if (w_rsp.done) begin
                        r_nd    <= w_res;
                        r_go    <= 1'b1;
                        r_state <= S_FR;
                    end
                end
                S_FR: begin
                    if (w_rsp.done) begin
                        r_count <= r_count + CW'(1);
                        r_state <= r_last ? S_BINIT : S_IDLE;
                    end
                end
                S_BINIT: begin
                    r_cur   <= r_prev;
                    r_tmp   <= r_prev.rhs;
                    r_bi    <= w_cnt_m1[AW-1:0];
                    r_go    <= 1'b1;
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    if (w_rsp.done) begin
                        r_sol   <= w_res;
                        r_fault <= r_fault | w_rsp.zero;
                        if (r_bi == '0) begin
                            r_ei    <= w_cnt_m1[AW-1:0];
                            r_state <= S_ERD;
                        end else begin
                            r_state <= S_BRD;
                        end
                    end
                end
                S_BRD: begin
                    r_cur   <= w_mr_data;
                    r_bi    <= r_bi - AW'(1);
                    r_go    <= 1'b1;
                    r_state <= S_BMS;
                end
                S_BMS: begin
                    if (w_rsp.done) begin
                        r_tmp   <= w_res;
                        r_go    <= 1'b1;
                        r_state <= S_BDIV;
                    end
                end
                S_ERD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (w_out_free) begin
                        r_ov      <= 1'b1;
                        r_o_idx   <= ROW_IDX_W'(r_ei);
                        r_o_sol   <= w_sr_data;
                        r_o_fault <= r_fault;
                        r_o_last  <= (r_ei == '0);
                        if (r_ei == '0) begin
                            // System done: the next row starts a fresh one.
                            r_count <= '0;
                            r_fault <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_ei    <= r_ei - AW'(1);
                            r_state <= S_ERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    tts_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_c     (w_c),
        .o_rsp   (w_rsp),
        .o_res   (w_res)
    );

    tts_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_mw_we),
        .i_waddr (w_mw_addr),
        .i_wdata (w_mw_data),
        .i_re    (w_mr_re),
        .i_raddr (w_mr_addr),
        .o_rdata (w_mr_data)
    );

    tts_ram #(
        .WIDTH ($bits(t_cpx)),
        .DEPTH (MAX_ROWS)
    ) u_sol_ram (
        .i_clk   (i_clk),
        .i_we    (w_sw_we),
        .i_waddr (r_bi),
        .i_wdata (w_res),
        .i_re    (w_sr_re),
        .i_raddr (r_ei),
        .o_rdata (w_sr_data)
    );

    assign o_out_valid   = r_ov;
    assign o_row_index   = r_o_idx;
    assign o_sol_re      = r_o_sol.re;
    assign o_sol_im      = r_o_sol.im;
    assign o_div_fault   = r_o_fault;
    assign o_last_result = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/core/tts_checker.sv =====
// ============================================================================
// tts_checker
// Port-level checks of the solver's result stream, bound to the top level.
// ============================================================================
`default_nettype none

`include "tridiagonal_thomas_solver_assert.svh"

module tts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [5:0]  o_row_index,
    input wire logic [31:0] o_sol_re,
    input wire logic [31:0] o_sol_im,
    input wire logic        o_div_fault,
    input wire logic        o_last_result
);

    // A waiting result stays put until it is taken.
    `TTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sol_re) && $stable(o_sol_im) && $stable(o_row_index) && $stable(o_div_fault), "result changed while stalled")

    // The final result of a system is always row 0.
    `TTS_ASSERT_IMPLIES(a_last_row0, o_out_valid && o_last_result, o_row_index == 6'd0, "last result not on row 0")

    // While a system is still being returned, no new row may enter.
    `TTS_ASSERT_IMPLIES(a_no_row_mid_results, o_out_valid && !o_last_result, !o_in_ready, "row accepted during results")

    // Results of one system come out in strictly descending row order.
    `TTS_ASSERT_NEXT(a_index_descends, o_out_valid && i_out_ready && !o_last_result, !o_out_valid || (o_row_index == $past(o_row_index) - 6'd1), "row index did not step down")

endmodule

bind tridiagonal_thomas_solver tts_checker u_tts_checker (.*);

`default_nettype wire

// ===== tb/tridiagonal_thomas_solver_tb.sv =====
// ----------------------------------------------------------------------------
// Tridiagonal solver testbench
// Feeds complex rows through the request channel and checks each solution entry
// against a hand-worked answer or a bit-accurate Thomas-algorithm bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tridiagonal_thomas_solver_tb;
    import tts_pkg::*;

    localparam int    ROWS_HELD  = 64;
    localparam t_word Q_ONE      = 32'sh0001_0000;
    localparam t_word W_MAX      = 32'sh7fff_ffff;
    localparam t_word W_MIN      = 32'sh8000_0000;
    localparam int    CYCLE_CAP  = 600000;

    // One row of the system as it is put on the request channel.
    typedef struct {
        t_word lre, lim, dre, dim, ure, uim, rre, rim;
        logic  last;
    } t_row_req;

    // One solution entry as the block should return it.
    typedef struct {
        logic [ROW_IDX_W-1:0] idx;
        t_word                re, im;
        logic                 fault, last;
    } t_sol_entry;

    // A directed row with an optional hand-worked answer for one-row systems.
    typedef struct {
        t_row_req   row;
        logic       typed;
        t_word      xre, xim;
        logic       xflt;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_word                i_lower_re, i_lower_im, i_diag_re, i_diag_im;
    t_word                i_upper_re, i_upper_im, i_rhs_re, i_rhs_im;
    logic                 i_last_row;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ROW_IDX_W-1:0] o_row_index;
    t_word                o_sol_re, o_sol_im;
    logic                 o_div_fault, o_last_result;

    tridiagonal_thomas_solver uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_lower_re(i_lower_re), .i_lower_im(i_lower_im),
        .i_diag_re(i_diag_re), .i_diag_im(i_diag_im),
        .i_upper_re(i_upper_re), .i_upper_im(i_upper_im),
        .i_rhs_re(i_rhs_re), .i_rhs_im(i_rhs_im),
        .i_last_row(i_last_row),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_row_index(o_row_index), .o_sol_re(o_sol_re), .o_sol_im(o_sol_im),
        .o_div_fault(o_div_fault), .o_last_result(o_last_result)
    );

    // Predictor state: the eliminated rows and the per-system fault.
    t_cpx       elim_diag [ROWS_HELD];
    t_cpx       elim_rhs  [ROWS_HELD];
    t_cpx       kept_upper[ROWS_HELD];
    int         rows_held;
    logic       sys_fault;

    t_sol_entry pending_sols[$];
    int         mismatches;
    int         idle_in_pct, idle_out_pct;
    int         cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clamp a wide signed value to the word range.
    function automatic t_word clamp_word(input logic signed [127:0] v);
        if (v > 128'sh7fff_ffff) return W_MAX;
        if (v < -128'sh8000_0000) return W_MIN;
        return t_word'(v[31:0]);
    endfunction

    // Drop FRAC_W fraction bits, rounding toward zero.
    function automatic logic signed [127:0] shift_trunc(input logic signed [127:0] v);
        logic signed [127:0] mag;
        mag = (v < 0) ? -v : v;
        mag = mag >>> FRAC_W;
        return (v < 0) ? -mag : mag;
    endfunction

    // c - a*b, exact product, then rescaled and clamped.
    function automatic t_cpx cpx_mul_sub(input t_cpx c, input t_cpx a, input t_cpx b);
        logic signed [127:0] ar, ai, br, bi, cr, ci, pr, pi;
        t_cpx r;
        ar = a.re; ai = a.im; br = b.re; bi = b.im; cr = c.re; ci = c.im;
        pr = ar * br - ai * bi;
        pi = ar * bi + ai * br;
        r.re = clamp_word(shift_trunc((cr <<< FRAC_W) - pr));
        r.im = clamp_word(shift_trunc((ci <<< FRAC_W) - pi));
        return r;
    endfunction

    // Quotient of a numerator with 2*FRAC_W fraction bits by |d|^2, toward zero.
    function automatic t_word frac_quot(input logic signed [127:0] num,
                                        input logic signed [127:0] den);
        logic signed [127:0] mag, q;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FRAC_W) / den;
        return clamp_word((num < 0) ? -q : q);
    endfunction

    // Complex division; a zero divisor gives zero and marks the system faulty.
    function automatic t_cpx cpx_div(input t_cpx n, input t_cpx d);
        logic signed [127:0] nr, ni, dr, di, den;
        t_cpx r;
        nr = n.re; ni = n.im; dr = d.re; di = d.im;
        den = dr * dr + di * di;
        r.re = '0;
        r.im = '0;
        if (den == 0) begin
            sys_fault = 1'b1;
            return r;
        end
        r.re = frac_quot(nr * dr + ni * di, den);
        r.im = frac_quot(ni * dr - nr * di, den);
        return r;
    endfunction

    // Forward elimination of one accepted row; on the last row, back
    // substitution and the queueing of the solution entries, highest first.
    function automatic void eliminate_row(input t_row_req rq, input logic queue_sols);
        t_cpx lo, dg, up, rh, piv;
        t_cpx sol[ROWS_HELD];
        t_sol_entry e;
        int n;
        lo = '{rq.lre, rq.lim}; dg = '{rq.dre, rq.dim};
        up = '{rq.ure, rq.uim}; rh = '{rq.rre, rq.rim};
        if (rows_held < ROWS_HELD) begin
            if (rows_held == 0) begin
                elim_diag[0] = dg;
                elim_rhs[0]  = rh;
            end else begin
                piv = cpx_div(lo, elim_diag[rows_held-1]);
                elim_diag[rows_held] = cpx_mul_sub(dg, piv, kept_upper[rows_held-1]);
                elim_rhs[rows_held]  = cpx_mul_sub(rh, piv, elim_rhs[rows_held-1]);
            end
            kept_upper[rows_held] = up;
            rows_held++;
        end
        if (!rq.last) return;
        n = rows_held;
        sol[n-1] = cpx_div(elim_rhs[n-1], elim_diag[n-1]);
        for (int i = n - 1; i > 0; i--)
            sol[i-1] = cpx_div(cpx_mul_sub(elim_rhs[i-1], kept_upper[i-1], sol[i]),
                               elim_diag[i-1]);
        if (queue_sols) begin
            for (int r = n - 1; r >= 0; r--) begin
                e.idx   = ROW_IDX_W'(r);
                e.re    = sol[r].re;
                e.im    = sol[r].im;
                e.fault = sys_fault;
                e.last  = (r == 0);
                pending_sols.push_back(e);
            end
        end
        rows_held = 0;
        sys_fault = 1'b0;
    endfunction

    // Present one row and hold it until the block takes the request.
    task automatic send_row(input t_row_req rq, input logic queue_sols);
        while ($urandom_range(99) < idle_in_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_lower_re <= rq.lre; i_lower_im <= rq.lim;
        i_diag_re  <= rq.dre; i_diag_im  <= rq.dim;
        i_upper_re <= rq.ure; i_upper_im <= rq.uim;
        i_rhs_re   <= rq.rre; i_rhs_im   <= rq.rim;
        i_last_row <= rq.last;
        do @(posedge i_clk); while (!o_in_ready);
        eliminate_row(rq, queue_sols);
    endtask

    function automatic t_word rand_word(input logic near_unit);
        if (!near_unit) return t_word'($urandom);
        return t_word'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    endfunction

    function automatic t_row_req rand_row(input logic near_unit, input logic last);
        t_row_req rq;
        rq.lre = rand_word(near_unit); rq.lim = rand_word(near_unit);
        rq.dre = rand_word(near_unit); rq.dim = rand_word(near_unit);
        rq.ure = rand_word(near_unit); rq.uim = rand_word(near_unit);
        rq.rre = rand_word(near_unit); rq.rim = rand_word(near_unit);
        // Bias the real diagonal of well-posed systems away from zero, with a rare zero pivot.
        if (near_unit) begin
            rq.dre = rq.dre + ($urandom_range(1) ? 32'sh0008_0000 : -32'sh0008_0000);
            if ($urandom_range(19) == 0) begin
                rq.dre = '0;
                rq.dim = '0;
            end
        end
        rq.last = last;
        return rq;
    endfunction

    // A whole system of the given length, all rows but the final one unmarked.
    task automatic send_system(input int len);
        logic near_unit;
        near_unit = ($urandom_range(3) != 0);
        for (int k = 0; k < len; k++)
            send_row(rand_row(near_unit, k == len - 1), 1'b1);
    endtask

    // The receiver checks each result against the oldest expected entry.
    always @(posedge i_clk) begin
        t_sol_entry exp_e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_sols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row %0d re %h im %h",
                             o_row_index, o_sol_re, o_sol_im);
            end else begin
                exp_e = pending_sols.pop_front();
                if (o_row_index !== exp_e.idx || o_sol_re !== exp_e.re ||
                    o_sol_im !== exp_e.im || o_div_fault !== exp_e.fault ||
                    o_last_result !== exp_e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp row %0d re %h im %h flt %b last %b, got row %0d re %h im %h flt %b last %b",
                                 exp_e.idx, exp_e.re, exp_e.im, exp_e.fault, exp_e.last,
                                 o_row_index, o_sol_re, o_sol_im, o_div_fault,
                                 o_last_result);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= idle_out_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_dir_row dir_rows[$];

    function automatic t_dir_row mk(input t_word lre, lim, dre, dim, ure, uim, rre, rim,
                                    input logic last, typed,
                                    input t_word xre, xim, input logic xflt);
        t_dir_row d;
        d.row = '{lre, lim, dre, dim, ure, uim, rre, rim, last};
        d.typed = typed;
        d.xre = xre; d.xim = xim; d.xflt = xflt;
        return d;
    endfunction

    initial begin
        t_sol_entry e;
        int issued;
        cycles = 0;
        mismatches = 0;
        rows_held = 0;
        sys_fault = 1'b0;
        idle_in_pct = 32;
        idle_out_pct = 56;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        {i_lower_re, i_lower_im, i_diag_re, i_diag_im} = '0;
        {i_upper_re, i_upper_im, i_rhs_re, i_rhs_im} = '0;
        i_last_row = 1'b0;

        // One-row systems that can be worked by hand: a unit diagonal passes
        // the right-hand side through, a zero diagonal faults to zero, and a
        // tiny diagonal drives the quotient into saturation.
        dir_rows.push_back(mk(W_MAX, W_MIN, Q_ONE, 0, W_MAX, W_MIN, 32'sh1234_5678, -5,
                              1, 1, 32'sh1234_5678, -5, 0));
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, Q_ONE, Q_ONE, 1, 1, 0, 0, 1));
        dir_rows.push_back(mk(0, 0, Q_ONE, 0, 0, 0, W_MAX, W_MIN, 1, 1, W_MAX, W_MIN, 0));
        dir_rows.push_back(mk(0, 0, 1, 0, 0, 0, Q_ONE, -Q_ONE, 1, 1, W_MAX, W_MIN, 0));
        dir_rows.push_back(mk(0, 0, 0, 1, 0, 0, 0, Q_ONE, 1, 1, W_MAX, 0, 0));
        // A three-row system at the field extremes, left to the predictor.
        dir_rows.push_back(mk(0, 0, W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(W_MIN, W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX,
                              0, 0, 0, 0, 0));
        dir_rows.push_back(mk(W_MAX, W_MAX, W_MAX, W_MAX, 0, 0, W_MIN, W_MIN, 1, 0, 0, 0, 0));
        // Well-posed three-row system.
        dir_rows.push_back(mk(0, 0, 4 * Q_ONE, 0, Q_ONE, 0, Q_ONE, 2 * Q_ONE, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(Q_ONE, 0, 4 * Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 3 * Q_ONE, 0,
                              0, 0, 0, 0, 0));
        dir_rows.push_back(mk(-Q_ONE, Q_ONE, 5 * Q_ONE, 0, 0, 0, -Q_ONE, Q_ONE, 1, 0, 0, 0, 0));
        // A zero diagonal on row 0 gives a zero divisor and faults the whole system.
        dir_rows.push_back(mk(0, 0, 0, 0, Q_ONE, 0, Q_ONE, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(Q_ONE, 0, Q_ONE, 0, 0, 0, Q_ONE, 0, 1, 0, 0, 0, 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[j]) begin
            send_row(dir_rows[j].row, !dir_rows[j].typed);
            if (dir_rows[j].typed) begin
                e = '{'0, dir_rows[j].xre, dir_rows[j].xim, dir_rows[j].xflt, 1'b1};
                pending_sols.push_back(e);
            end
        end

        // Three idling phases; the last one also carries a system longer than
        // the row memory, whose surplus rows are dropped.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                idle_in_pct = 56;
                idle_out_pct = 32;
            end else if (ph == 2) begin
                idle_in_pct = 0;
                idle_out_pct = 0;
            end
            issued = 0;
            while (issued < 8) begin
                int len;
                len = $urandom_range(1, 6);
                send_system(len);
                issued += len;
            end
            if (ph == 2) send_system(ROWS_HELD + 2);
        end
        i_in_valid <= 1'b0;

        while (pending_sols.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && pending_sols.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== tridiagonal_thomas_solver.f =====
+incdir+rtl/core
rtl/core/tts_pkg.sv
rtl/core/tts_ram.sv
rtl/core/tts_div.sv
rtl/core/tts_calc.sv
rtl/core/tridiagonal_thomas_solver.sv
rtl/core/tts_checker.sv
tb/tridiagonal_thomas_solver_tb.sv
